>>> rtl/core/nvf_pkg.sv
// Package for the neighbor view filter: shared types, codes and constants.
// Used by nvf_front, nvf_back and neighbor_view_filter. No dependencies.
package nvf_pkg;

   // Register index codes on the CSR write channel
   typedef enum logic [1:0] {
      REG_ROBOT_COUNT     = 2'd0,
      REG_VIEW_RANGE      = 2'd1,
      REG_HALF_VIEW_ANGLE = 2'd2
   } csr_index_type;

   // Request kinds
   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam int CORDIC_STEPS = 16;
   localparam logic signed [15:0] FAKE_POS = 16'sd25600;
   localparam logic signed [17:0] GAIN_Q16 = 18'sd39797;

   typedef struct packed {
      logic [3:0]  robot_count;
      logic [14:0] view_range;
      logic [15:0] half_view_angle;
   } cfg_type;

   // Classified request handed from front to back
   typedef struct packed {
      logic        is_query;
      logic        idx_ok;
      logic [2:0]  idx;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] heading;
   } item_type;

   // arctan(2^-i), pi = 2^23
   function automatic logic signed [25:0] atan_at(input logic [3:0] i);
      logic signed [25:0] v;
      begin
         case (i)
            4'd0:    v = 26'sd2097152;
            4'd1:    v = 26'sd1238021;
            4'd2:    v = 26'sd654136;
            4'd3:    v = 26'sd332050;
            4'd4:    v = 26'sd166669;
            4'd5:    v = 26'sd83416;
            4'd6:    v = 26'sd41718;
            4'd7:    v = 26'sd20860;
            4'd8:    v = 26'sd10430;
            4'd9:    v = 26'sd5215;
            4'd10:   v = 26'sd2608;
            4'd11:   v = 26'sd1304;
            4'd12:   v = 26'sd652;
            4'd13:   v = 26'sd326;
            4'd14:   v = 26'sd163;
            default: v = 26'sd81;
         endcase
         return v;
      end
   endfunction

endpackage

>>> rtl/core/nvf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nvf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/nvf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on nvf_pkg.
module nvf_front #(
   parameter int MAX_ROBOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,  // robot_index, pos_x, pos_y, heading
   input  logic              req_tuser,  // mode
   output logic              item_valid,
   output nvf_pkg::item_type item,
   input  logic              item_pop
);
   import nvf_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   new_item;
   logic       push;

   // classify the incoming request
   always_comb begin
      new_item.is_query = (req_tuser == MODE_QUERY);
      new_item.idx      = req_tdata[2:0];
      new_item.idx_ok   = (32'(req_tdata[2:0]) < MAX_ROBOTS);
      new_item.pos_x    = req_tdata[18:3];
      new_item.pos_y    = req_tdata[34:19];
      new_item.heading  = req_tdata[50:35];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (item_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(item_pop);
      end
   end

endmodule

>>> rtl/core/nvf_back.sv
// Back end: pose table, per-agent range test, CORDIC rotation and angle test.
// Depends on nvf_pkg and nvf_ram.
module nvf_back #(
   parameter int MAX_ROBOTS = 8,
   parameter int COORD_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  nvf_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  nvf_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,  // target_index, local_x, local_y
   output logic              rsp_tuser,  // seen
   output logic              rsp_tlast
);
   import nvf_pkg::*;

   localparam int AW = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
   localparam int CW = $clog2(MAX_ROBOTS + 1);
   localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

   typedef enum logic [3:0] {
      S_IDLE, S_OBS, S_TGT, S_DX2, S_DY2, S_ROT0, S_ROT, S_GX, S_GY,
      S_VEC0, S_VEC, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] j_ff, j_in, n_ff, n_in;
   logic [2:0]    idx_ff, idx_in;
   logic          obs_ok_ff, obs_ok_in, pair_ok_ff, pair_ok_in;
   logic [15:0]   obs_x_ff, obs_x_in, obs_y_ff, obs_y_in, obs_h_ff, obs_h_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [29:0]   vr2_ff, vr2_in;
   logic signed [28:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic [3:0]    i_ff, i_in;
   logic signed [22:0] lx_ff, lx_in, ly_ff, ly_in;
   logic          seen_ff, seen_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_seen_ff, rsp_seen_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [2:0]    rsp_tgt_ff, rsp_tgt_in;
   logic [15:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic [MAX_ROBOTS-1:0] valid_ff, valid_in;
   logic          rd_valid_ff;
   logic [AW-1:0] rd_addr;
   logic [47:0]   rd_data;
   logic          wr_en;

   logic signed [29:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [47:0] prod, prod_rnd;

   // pose table: {heading, y, x}
   nvf_ram #(.WIDTH(48), .DEPTH(MAX_ROBOTS)) u_pose_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(item.idx)),
      .wr_data ({item.heading, item.pos_y, item.pos_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_en    = (state_ff == S_IDLE) && item_valid && !item.is_query && item.idx_ok;
   assign item_pop = (state_ff == S_IDLE) && item_valid;

   // read address follows the agent about to be examined
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = AW'(item.idx);
         S_OBS:   rd_addr = '0;
         S_EMIT:  rd_addr = AW'(j_ff + CW'(1));
         default: rd_addr = AW'(j_ff);
      endcase
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_OBS: begin
            mul_a = $signed({15'b0, cfg.view_range});
            mul_b = $signed({3'b0, cfg.view_range});
         end
         S_DX2: begin
            mul_a = 30'(dx_ff);
            mul_b = 18'(dx_ff);
         end
         S_DY2: begin
            mul_a = 30'(dy_ff);
            mul_b = 18'(dy_ff);
         end
         S_GX: begin
            mul_a = 30'(x_ff);
            mul_b = GAIN_Q16;
         end
         S_GY: begin
            mul_a = 30'(y_ff);
            mul_b = GAIN_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod     = 48'(mul_a) * 48'(mul_b);
      prod_rnd = prod + 48'sd8388608;
   end

   // sequencer
   always_comb begin
      logic [15:0] ang, rem, qsum;
      logic [1:0]  q;
      logic signed [28:0] x0, y0, xs, ys;
      logic signed [25:0] thr;
      logic signed [32:0] sx, sy;
      logic        last;
      begin
         state_in = state_ff;   j_in = j_ff;         n_in = n_ff;
         idx_in = idx_ff;       obs_ok_in = obs_ok_ff; pair_ok_in = pair_ok_ff;
         obs_x_in = obs_x_ff;   obs_y_in = obs_y_ff; obs_h_in = obs_h_ff;
         dx_in = dx_ff;         dy_in = dy_ff;       acc_in = acc_ff;
         vr2_in = vr2_ff;       x_in = x_ff;         y_in = y_ff;
         z_in = z_ff;           i_in = i_ff;         lx_in = lx_ff;
         ly_in = ly_ff;         seen_in = seen_ff;   valid_in = valid_ff;
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
         rsp_seen_in = rsp_seen_ff; rsp_last_in = rsp_last_ff; rsp_tgt_in = rsp_tgt_ff;
         rsp_x_in = rsp_x_ff;   rsp_y_in = rsp_y_ff;
         xs = x_ff >>> i_ff;    ys = y_ff >>> i_ff;
         ang  = 16'h0000 - obs_h_ff;
         qsum = ang + 16'h2000;
         q    = qsum[15:14];
         rem  = ang - {q, 14'b0};
         x0 = 29'(dx_ff) <<< 8;
         y0 = 29'(dy_ff) <<< 8;
         thr = $signed({2'b0, cfg.half_view_angle, 8'b0});
         sx = 33'(lx_ff);
         sy = 33'(ly_ff);
         last = ((j_ff + CW'(1)) == n_ff);

         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  if (item.is_query) begin
                     idx_in    = item.idx;
                     obs_ok_in = item.idx_ok;
                     if (item.idx_ok == 1'b0 && 1'b0) begin
                        obs_ok_in = 1'b0;
                     end
                     if (cfg.robot_count == 4'd0) begin
                        n_in = CW'(1);
                     end else if (32'(cfg.robot_count) > MAX_ROBOTS) begin
                        n_in = CW'(MAX_ROBOTS);
                     end else begin
                        n_in = CW'(cfg.robot_count);
                     end
                     state_in = S_OBS;
                  end else if (item.idx_ok) begin
                     valid_in[AW'(item.idx)] = 1'b1;
                  end
               end
            end
            S_OBS: begin
               obs_x_in = rd_valid_ff ? rd_data[15:0]  : '0;
               obs_y_in = rd_valid_ff ? rd_data[31:16] : '0;
               obs_h_in = rd_valid_ff ? rd_data[47:32] : '0;
               vr2_in   = 30'(prod);
               j_in     = '0;
               state_in = S_TGT;
            end
            S_TGT: begin
               dx_in = $signed(17'(signed'(rd_valid_ff ? rd_data[15:0] : 16'h0)))
                     - $signed(17'(signed'(obs_x_ff)));
               dy_in = $signed(17'(signed'(rd_valid_ff ? rd_data[31:16] : 16'h0)))
                     - $signed(17'(signed'(obs_y_ff)));
               pair_ok_in = obs_ok_ff && (32'(j_ff) != 32'(idx_ff));
               state_in = S_DX2;
            end
            S_DX2: begin
               acc_in   = 36'(prod);
               state_in = S_DY2;
            end
            S_DY2: begin
               acc_in   = acc_ff + 36'(prod);
               state_in = S_ROT0;
            end
            S_ROT0: begin
               seen_in = 1'b0;
               if (pair_ok_ff && ($unsigned(acc_ff) <= 36'(vr2_ff))) begin
                  case (q)
                     2'd0: begin x_in = x0;  y_in = y0;  end
                     2'd1: begin x_in = -y0; y_in = x0;  end
                     2'd2: begin x_in = -x0; y_in = -y0; end
                     default: begin x_in = y0; y_in = -x0; end
                  endcase
                  z_in = 26'(signed'(rem)) <<< 8;
                  i_in = '0;
                  state_in = S_ROT;
               end else begin
                  state_in = S_EMIT;
               end
            end
            S_ROT: begin
               if (z_ff >= 0) begin
                  x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_at(i_ff);
               end else begin
                  x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_at(i_ff);
               end
               i_in = i_ff + 4'd1;
               if (i_ff == 4'(CORDIC_STEPS - 1)) begin
                  state_in = S_GX;
               end
            end
            S_GX: begin
               lx_in    = prod_rnd[46:24];
               state_in = S_GY;
            end
            S_GY: begin
               ly_in    = prod_rnd[46:24];
               state_in = S_VEC0;
            end
            S_VEC0: begin
               if (lx_ff < 0) begin
                  seen_in  = 1'b0;
                  state_in = S_EMIT;
               end else if (ly_ff == 0) begin
                  seen_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  x_in = 29'(lx_ff) <<< 8;
                  y_in = (ly_ff < 0) ? (-(29'(ly_ff)) <<< 8) : (29'(ly_ff) <<< 8);
                  z_in = '0;
                  i_in = '0;
                  state_in = S_VEC;
               end
            end
            S_VEC: begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_at(i_ff);
               end else begin
                  x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_at(i_ff);
               end
               i_in = i_ff + 4'd1;
               if (i_ff == 4'(CORDIC_STEPS - 1)) begin
                  seen_in  = (z_in <= thr);
                  state_in = S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_tgt_in   = 3'(j_ff);
                  rsp_seen_in  = seen_ff;
                  rsp_last_in  = last;
                  if (seen_ff) begin
                     rsp_x_in = 16'((sx > SAT_HI) ? SAT_HI : ((sx < SAT_LO) ? SAT_LO : sx));
                     rsp_y_in = 16'((sy > SAT_HI) ? SAT_HI : ((sy < SAT_LO) ? SAT_LO : sy));
                  end else begin
                     rsp_x_in = FAKE_POS;
                     rsp_y_in = FAKE_POS;
                  end
                  if (last) begin
                     state_in = S_IDLE;
                  end else begin
                     j_in     = j_ff + CW'(1);
                     state_in = S_TGT;
                  end
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_valid_ff <= valid_ff[rd_addr];
      j_ff <= j_in;           n_ff <= n_in;           idx_ff <= idx_in;
      obs_ok_ff <= obs_ok_in; pair_ok_ff <= pair_ok_in;
      obs_x_ff <= obs_x_in;   obs_y_ff <= obs_y_in;   obs_h_ff <= obs_h_in;
      dx_ff <= dx_in;         dy_ff <= dy_in;         acc_ff <= acc_in;
      vr2_ff <= vr2_in;       x_ff <= x_in;           y_ff <= y_in;
      z_ff <= z_in;           i_ff <= i_in;           lx_ff <= lx_in;
      ly_ff <= ly_in;         seen_ff <= seen_in;
      rsp_seen_ff <= rsp_seen_in; rsp_last_ff <= rsp_last_in; rsp_tgt_ff <= rsp_tgt_in;
      rsp_x_ff <= rsp_x_in;   rsp_y_ff <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_y_ff, rsp_x_ff, rsp_tgt_ff};
   assign rsp_tuser  = rsp_seen_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/core/neighbor_view_filter.sv
// Neighbor view filter top: CSR registers, front queue and back-end engine.
// An update request is written to the pose table from the idle state; a query fetches the
// observer, then tests each agent for range; agents in range also pass through the 16-step
// CORDIC rotation loop and, where needed, the 16-step vectoring loop in the back end.
// Results leave through an output register; requests queue two deep in front.
// Synchronous active-high reset clears the pose table (valid bits) and loads CSR defaults.
module neighbor_view_filter #(
   parameter int MAX_ROBOTS = 8,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // robot_index, pos_x, pos_y, heading
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // target_index, local_x, local_y
   output logic        rsp_tuser,  // seen
   output logic        rsp_tlast,  // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import nvf_pkg::*;

   cfg_type  cfg_ff;
   logic     item_valid, item_pop;
   item_type item;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.robot_count     <= 4'd4;
         cfg_ff.view_range      <= 15'd7680;
         cfg_ff.half_view_angle <= 16'd13653;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_ROBOT_COUNT:     cfg_ff.robot_count     <= csr_data[3:0];
            REG_VIEW_RANGE:      cfg_ff.view_range      <= csr_data[14:0];
            REG_HALF_VIEW_ANGLE: cfg_ff.half_view_angle <= csr_data;
            default: ;
         endcase
      end
   end

   nvf_front #(.MAX_ROBOTS(MAX_ROBOTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   nvf_back #(.MAX_ROBOTS(MAX_ROBOTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tb.sv
// Self-checking bench for neighbor_view_filter: pose updates, observer queries, CSR phases.
// Depends on nvf_pkg and the neighbor_view_filter RTL only.
import nvf_pkg::*;

// Expected view of one agent as seen by an observer
typedef struct {
   logic [2:0]         target;
   logic               seen;
   logic signed [15:0] local_x;
   logic signed [15:0] local_y;
   logic               last;
} view_result_type;

class view_scoreboard;
   logic [15:0]     pose_x [8];
   logic [15:0]     pose_y [8];
   logic [15:0]     pose_h [8];
   logic [3:0]      robot_count;
   logic [14:0]     view_range;
   logic [15:0]     half_angle;
   view_result_type expected_views[$];
   int              mismatches;

   function new();
      for (int i = 0; i < 8; i++) begin
         pose_x[i] = '0; pose_y[i] = '0; pose_h[i] = '0;
      end
      robot_count = 4'd4;
      view_range  = 15'd7680;
      half_angle  = 16'd13653;
      mismatches  = 0;
   endfunction

   function void set_reg(csr_index_type idx, logic [15:0] value);
      case (idx)
         REG_ROBOT_COUNT:     robot_count = value[3:0];
         REG_VIEW_RANGE:      view_range  = value[14:0];
         REG_HALF_VIEW_ANGLE: half_angle  = value;
         default: ;
      endcase
   endfunction

   static function longint atan_step(int i);
      longint tab [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                           20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return tab[i];
   endfunction

   // Rotate the offset by -heading: quarter turns exact, remainder by CORDIC
   static function void rotate_offset(longint dx, longint dy, logic [15:0] head,
                                      output longint lx, output longint ly);
      longint a, q, r, x, y, z, t, xs, ys;
      a = (65536 - longint'(head)) & 16'hFFFF;
      q = ((a + 8192) >> 14) & 3;
      r = (a - q * 16384) & 16'hFFFF;
      if (r >= 32768) r -= 65536;
      x = dx * 256;
      y = dy * 256;
      for (int i = 0; i < q; i++) begin
         t = x; x = -y; y = t;
      end
      z = r * 256;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_step(i);
         end else begin
            x += ys; y -= xs; z += atan_step(i);
         end
      end
      lx = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
      ly = (y * 39797 + (64'sd1 <<< 23)) >>> 24;
   endfunction

   // Bearing of a point in the observer frame, pi = 2^23
   static function longint bearing(longint lx, longint ly);
      longint x, y, z, xs, ys;
      if (ly == 0) return 0;
      x = lx * 256;
      y = (ly < 0 ? -ly : ly) * 256;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += atan_step(i);
         end else begin
            x -= ys; y += xs; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   static function longint clamp16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function void note_request(logic mode, logic [2:0] idx, logic [15:0] px,
                              logic [15:0] py, logic [15:0] hd);
      int              n;
      longint          dx, dy, lx, ly;
      logic            vis;
      view_result_type v;
      if (mode == MODE_UPDATE) begin
         pose_x[idx] = px; pose_y[idx] = py; pose_h[idx] = hd;
         return;
      end
      n = robot_count;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      for (int j = 0; j < n; j++) begin
         vis = 1'b0;
         lx = 0; ly = 0;
         if (j != idx) begin
            dx = longint'($signed(pose_x[j])) - longint'($signed(pose_x[idx]));
            dy = longint'($signed(pose_y[j])) - longint'($signed(pose_y[idx]));
            if (dx * dx + dy * dy <= longint'(view_range) * longint'(view_range)) begin
               rotate_offset(dx, dy, pose_h[idx], lx, ly);
               if (lx >= 0 && bearing(lx, ly) <= longint'(half_angle) * 256) vis = 1'b1;
            end
         end
         v.target  = j[2:0];
         v.seen    = vis;
         v.local_x = vis ? 16'(clamp16(lx)) : FAKE_POS;
         v.local_y = vis ? 16'(clamp16(ly)) : FAKE_POS;
         v.last    = (j == n - 1);
         expected_views.insert(expected_views.size(), v);
      end
   endfunction

   function void check_result(view_result_type got);
      view_result_type exp;
      if (expected_views.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected result target=%0d seen=%0b x=%0d y=%0d last=%0b",
                     got.target, got.seen, got.local_x, got.local_y, got.last);
         return;
      end
      exp = expected_views.pop_front();
      if (got.target !== exp.target || got.seen !== exp.seen || got.local_x !== exp.local_x
          || got.local_y !== exp.local_y || got.last !== exp.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: exp t=%0d s=%0b x=%0d y=%0d l=%0b got t=%0d s=%0b x=%0d y=%0d l=%0b",
                     exp.target, exp.seen, exp.local_x, exp.local_y, exp.last,
                     got.target, got.seen, got.local_x, got.local_y, got.last);
      end
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   longint         cycle_count = 0;
   view_scoreboard views = new();

   neighbor_view_filter uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1500000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : (($urandom % 100) >= rx_idle_pct);

   // Result monitor
   always @(posedge clock) begin
      view_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.target  = rsp_tdata[2:0];
         got.seen    = rsp_tuser;
         got.local_x = rsp_tdata[18:3];
         got.local_y = rsp_tdata[34:19];
         got.last    = rsp_tlast;
         views.check_result(got);
      end
   end

   task automatic send_request(logic mode, logic [2:0] idx, logic [15:0] px,
                               logic [15:0] py, logic [15:0] hd);
      @(negedge clock);
      while (($urandom % 100) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {5'b0, hd, py, px, idx};
      do @(posedge clock); while (!req_tready);
      views.note_request(mode, idx, px, py, hd);
   endtask

   // Let the block go idle: all results in, then room for a trailing update
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (views.expected_views.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      views.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(logic [15:0] cnt, logic [15:0] rng, logic [15:0] ang);
      write_reg(REG_ROBOT_COUNT, cnt);
      write_reg(REG_VIEW_RANGE, rng);
      write_reg(REG_HALF_VIEW_ANGLE, ang);
   endtask

   // Mostly nearby poses so that agents fall in range; some full-scale
   task automatic random_traffic(int count);
      logic [15:0] px, py;
      for (int k = 0; k < count; k++) begin
         if (($urandom % 100) < 60) begin
            if (($urandom % 8) == 0) begin
               px = 16'($urandom); py = 16'($urandom);
            end else begin
               px = 16'($signed($urandom_range(0, 4000)) - 2000);
               py = 16'($signed($urandom_range(0, 4000)) - 2000);
            end
            send_request(MODE_UPDATE, 3'($urandom_range(0, 7)), px, py, 16'($urandom));
         end else begin
            send_request(MODE_QUERY, 3'($urandom_range(0, 7)), 16'($urandom),
                         16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset table, extremes, coincident agents, wide and narrow views
      send_request(MODE_QUERY, 3'd0, 16'h0, 16'h0, 16'h0);
      drain();
      set_config(16'd8, 16'd32767, 16'd32768);
      send_request(MODE_UPDATE, 3'd0, 16'h8000, 16'h8000, 16'h8000);
      send_request(MODE_UPDATE, 3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_request(MODE_UPDATE, 3'd2, 16'h0100, 16'h0000, 16'h0000);
      send_request(MODE_UPDATE, 3'd3, 16'h0100, 16'h0000, 16'h4000);
      send_request(MODE_UPDATE, 3'd4, 16'hFF00, 16'h0080, 16'hC000);
      send_request(MODE_UPDATE, 3'd5, 16'h0000, 16'h0200, 16'h2000);
      send_request(MODE_UPDATE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int i = 0; i < 8; i++)
         send_request(MODE_QUERY, i[2:0], 16'h0, 16'h0, 16'h0);
      drain();
      set_config(16'd0, 16'd0, 16'd0);
      send_request(MODE_QUERY, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();
      set_config(16'd15, 16'd1024, 16'd16384);
      send_request(MODE_QUERY, 3'd2, 16'h0, 16'h0, 16'h0);
      send_request(MODE_QUERY, 3'd6, 16'h0, 16'h0, 16'h0);
      drain();
      set_config(16'd3, 16'd4000, 16'd0);
      send_request(MODE_QUERY, 3'd5, 16'h0, 16'h0, 16'h0);
      drain();

      // Random phases, each with its own register setting and idle pattern
      set_config(16'd8, 16'd3000, 16'd13653);
      tx_idle_pct = 20; rx_idle_pct = 66;
      random_traffic(130);
      drain();
      set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 32767)),
                 16'($urandom_range(0, 32768)));
      tx_idle_pct = 66; rx_idle_pct = 20;
      random_traffic(130);
      drain();
      set_config(16'd7, 16'd32767, 16'($urandom_range(2000, 20000)));
      tx_idle_pct = 0; rx_idle_pct = 0;
      random_traffic(130);
      drain();

      if (views.mismatches == 0 && views.expected_views.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
